// ===== sv/ip_packet_header_classifier_top_defines.svh =====
// ----------------------------------------------------------------------------
// IP packet header classifier - assertion macros
// Shared property macros for the checker. Each macro expects signals named
// clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef IP_PACKET_HEADER_CLASSIFIER_TOP_DEFINES_SVH
`define IP_PACKET_HEADER_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPHC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iphc checker: property violated");

// Next-cycle implication, checked outside reset.
`define IPHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iphc checker: property violated");

`endif

// ===== sv/iphc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - package
// Types, protocol constants and a small helper function shared by the design and checker files.
// ----------------------------------------------------------------------------
package iphc_pkg;

  localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;

  localparam logic [15:0] KIND_V4   = 16'h0800;
  localparam logic [15:0] KIND_V6   = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [15:0] PORT_NTP   = 16'd123;
  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_HTTPS = 16'd443;

  localparam logic [15:0] V4_MIN_LEN     = 16'd20;
  localparam logic [15:0] V6_MIN_LEN     = 16'd40;
  localparam logic [5:0]  V6_HDR_LEN     = 6'd40;
  localparam logic [15:0] V4_PROTO_POS   = 16'd9;
  localparam logic [15:0] V6_PROTO_POS   = 16'd6;
  localparam logic [5:0]  TCP_MIN_HDR    = 6'd20;
  localparam logic [16:0] TCP_MIN_LEN    = 17'd20;
  localparam logic [16:0] UDP_MIN_LEN    = 17'd8;
  localparam logic [15:0] TCP_OFFSET_POS = 16'd12;
  localparam logic [16:0] HTTP_MIN_BYTES = 17'd12;
  localparam logic [15:0] HTTP_MARK_LEN  = 16'd5;
  localparam logic [15:0] STATUS_POS     = 16'd9;

  typedef enum logic [1:0] {
    TRN_TCP   = 2'd0,
    TRN_UDP   = 2'd1,
    TRN_OTHER = 2'd2
  } transport_t;

  typedef enum logic [2:0] {
    SVC_NTP     = 3'd0,
    SVC_HTTP    = 3'd1,
    SVC_QUIC    = 3'd2,
    SVC_TLS     = 3'd3,
    SVC_UNKNOWN = 3'd4
  } service_t;

  // Status text scanner: leading blanks or sign, digits, stopped.
  typedef enum logic [1:0] {
    SCAN_LEAD   = 2'd0,
    SCAN_DIGITS = 2'd1,
    SCAN_STOP   = 2'd3
  } scan_phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] ether_kind;
    logic        last_byte;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic        accepted;
    logic        ip_version;
    transport_t  transport;
    service_t    service;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] packet_length;
    logic [15:0] http_status;
  } result_t;

  // Expected bytes of the "HTTP/" payload mark.
  function automatic logic [7:0] http_mark(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h48;  // H
      3'd1:    ch = 8'h54;  // T
      3'd2:    ch = 8'h54;  // T
      3'd3:    ch = 8'h50;  // P
      3'd4:    ch = 8'h2F;  // slash
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/iphc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - input channel interface
// Valid/ready channel carrying one packet byte per transaction.
// ----------------------------------------------------------------------------
interface iphc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] ether_kind;
  logic        last_byte;

  modport source (output valid, output data_byte, output ether_kind, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input ether_kind, input last_byte,
                output ready);
endinterface

// ===== sv/iphc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - result channel interface
// Valid/ready channel carrying one classification result per transaction.
// ----------------------------------------------------------------------------
interface iphc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic        ip_version;
  logic [1:0]  transport;
  logic [2:0]  service;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] packet_length;
  logic [15:0] http_status;

  modport source (output valid, output accepted, output ip_version, output transport,
                  output service, output source_port, output dest_port,
                  output packet_length, output http_status, input ready);
  modport sink (input valid, input accepted, input ip_version, input transport,
                input service, input source_port, input dest_port,
                input packet_length, input http_status, output ready);
endinterface

// ===== sv/iphc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - input register
// Captures one byte transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module iphc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  iphc_in_if.sink           in_ch,
  input  logic              take,
  output iphc_pkg::stage_t  stage
);

  logic               valid_r;
  logic               valid_nxt;
  iphc_pkg::in_item_t item_r;
  logic               in_fire;

  assign in_ch.ready = !valid_r || take;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.data_byte  <= in_ch.data_byte;
      item_r.ether_kind <= in_ch.ether_kind;
      item_r.last_byte  <= in_ch.last_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

// ===== sv/iphc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - byte parser
// Holds the per-packet parse state, folds in one byte per take and forms
// the classification result from the updated state on the last byte.
// ----------------------------------------------------------------------------
module iphc_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  iphc_pkg::in_item_t  item,
  output iphc_pkg::result_t   result
);

  logic [15:0]           pos_r, pos_nxt;
  logic [15:0]           kind_r, kind_nxt;
  logic [5:0]            toff_r, toff_nxt;
  logic [7:0]            proto_r, proto_nxt;
  logic [15:0]           src_r, src_nxt;
  logic [15:0]           dst_r, dst_nxt;
  logic [5:0]            tcp_hdr_r, tcp_hdr_nxt;
  logic                  prefix_ok_r, prefix_ok_nxt;
  iphc_pkg::scan_phase_t phase_r, phase_nxt;
  logic [15:0]           accum_r, accum_nxt;

  logic [7:0]  b;
  logic        first;
  logic        in_range;
  logic [15:0] kind_now;
  logic [5:0]  toff_now;
  logic        is_v4;
  logic        is_v6;
  logic        upd;
  logic [15:0] t;
  logic [15:0] q;
  logic        in_payload;
  logic        scan_en;
  logic        is_digit;
  logic        is_blank;
  logic        is_plus;
  logic [3:0]  dval;
  logic [19:0] prod;

  assign b        = item.data_byte;
  assign first    = (pos_r == 16'd0);
  assign in_range = (pos_r < iphc_pkg::MAX_PACKET_BYTES);
  assign kind_now = first ? item.ether_kind : kind_r;
  assign toff_now = !first ? toff_r :
                    (item.ether_kind == iphc_pkg::KIND_V4) ? {b[3:0], 2'b00} :
                    iphc_pkg::V6_HDR_LEN;
  assign is_v4    = (kind_now == iphc_pkg::KIND_V4);
  assign is_v6    = (kind_now == iphc_pkg::KIND_V6);

  // Offset of this byte inside the transport header, and inside the TCP payload.
  assign t          = pos_r - {10'd0, toff_now};
  assign q          = t - {10'd0, tcp_hdr_r};
  assign upd        = in_range && (is_v4 || is_v6) && (pos_r >= {10'd0, toff_now});
  assign in_payload = (tcp_hdr_r >= iphc_pkg::TCP_MIN_HDR) && (t >= {10'd0, tcp_hdr_r});
  assign scan_en    = upd && in_payload && (q >= iphc_pkg::STATUS_POS);

  assign is_digit = (b >= 8'h30) && (b <= 8'h39);
  assign is_blank = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  assign is_plus  = (b == 8'h2B);
  assign dval     = 4'(b - 8'h30);
  assign prod     = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) + {16'd0, dval};

  // Per-byte update of the header fields.
  always_comb begin
    pos_nxt       = in_range ? pos_r + 16'd1 : pos_r;
    kind_nxt      = first ? item.ether_kind : kind_r;
    toff_nxt      = toff_now;
    proto_nxt     = proto_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    tcp_hdr_nxt   = tcp_hdr_r;
    prefix_ok_nxt = prefix_ok_r;
    if (in_range && ((is_v4 && pos_r == iphc_pkg::V4_PROTO_POS) ||
                     (is_v6 && pos_r == iphc_pkg::V6_PROTO_POS))) begin
      proto_nxt = b;
    end
    if (upd) begin
      case (t)
        16'd0: src_nxt = {b, src_r[7:0]};
        16'd1: src_nxt = {src_r[15:8], b};
        16'd2: dst_nxt = {b, dst_r[7:0]};
        16'd3: dst_nxt = {dst_r[15:8], b};
        iphc_pkg::TCP_OFFSET_POS: tcp_hdr_nxt = {b[7:4], 2'b00};
        default: begin
          if (in_payload) begin
            if (q == 16'd0) begin
              prefix_ok_nxt = (b == iphc_pkg::http_mark(3'd0));
            end else if (q < iphc_pkg::HTTP_MARK_LEN) begin
              if (b != iphc_pkg::http_mark(q[2:0])) begin
                prefix_ok_nxt = 1'b0;
              end
            end
          end
        end
      endcase
    end
  end

  // Status scanner phase.
  always_comb begin
    phase_nxt = phase_r;
    if (scan_en) begin
      unique case (phase_r)
        iphc_pkg::SCAN_LEAD: begin
          if (is_plus || is_digit) begin
            phase_nxt = iphc_pkg::SCAN_DIGITS;
          end else if (!is_blank) begin
            phase_nxt = iphc_pkg::SCAN_STOP;
          end
        end
        iphc_pkg::SCAN_DIGITS: begin
          if (!is_digit) begin
            phase_nxt = iphc_pkg::SCAN_STOP;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Status scanner value, saturating at 16 bits.
  always_comb begin
    accum_nxt = accum_r;
    if (scan_en) begin
      unique case (phase_r)
        iphc_pkg::SCAN_LEAD: begin
          if (is_digit) begin
            accum_nxt = {12'd0, dval};
          end else if (!is_blank && !is_plus) begin
            accum_nxt = 16'd0;
          end
        end
        iphc_pkg::SCAN_DIGITS: begin
          if (is_digit) begin
            accum_nxt = (prod[19:16] != 4'd0) ? 16'hFFFF : prod[15:0];
          end
        end
        default: accum_nxt = accum_r;
      endcase
    end
  end

  // Result formed from the state as it stands after this byte.
  logic        acc_ok;
  logic [16:0] len17;
  logic [16:0] toff17;
  logic        tcp_fit;
  logic        udp_fit;
  logic [15:0] sp;
  logic [15:0] dp;
  logic [15:0] pick;
  logic        http_fit;

  assign len17  = {1'b0, pos_nxt};
  assign toff17 = {11'd0, toff_nxt};
  assign acc_ok = ((kind_nxt == iphc_pkg::KIND_V4) && (pos_nxt >= iphc_pkg::V4_MIN_LEN)) ||
                  ((kind_nxt == iphc_pkg::KIND_V6) && (pos_nxt >= iphc_pkg::V6_MIN_LEN));
  assign tcp_fit = (proto_nxt == iphc_pkg::PROTO_TCP) &&
                   (len17 >= toff17 + iphc_pkg::TCP_MIN_LEN);
  assign udp_fit = (proto_nxt == iphc_pkg::PROTO_UDP) &&
                   (len17 >= toff17 + iphc_pkg::UDP_MIN_LEN);
  assign http_fit = (tcp_hdr_nxt >= iphc_pkg::TCP_MIN_HDR) &&
                    (len17 >= toff17 + {11'd0, tcp_hdr_nxt} + iphc_pkg::HTTP_MIN_BYTES);

  always_comb begin
    result               = '0;
    result.transport     = iphc_pkg::TRN_OTHER;
    result.service       = iphc_pkg::SVC_UNKNOWN;
    result.packet_length = pos_nxt;
    sp                   = 16'd0;
    dp                   = 16'd0;
    if (acc_ok) begin
      result.accepted   = 1'b1;
      result.ip_version = (kind_nxt == iphc_pkg::KIND_V6);
      if (tcp_fit) begin
        result.transport = iphc_pkg::TRN_TCP;
      end else if (udp_fit) begin
        result.transport = iphc_pkg::TRN_UDP;
      end
      if (tcp_fit || udp_fit) begin
        sp = src_nxt;
        dp = dst_nxt;
      end
    end
    result.source_port = sp;
    result.dest_port   = dp;
    pick = ((sp == iphc_pkg::PORT_NTP) || (sp == iphc_pkg::PORT_HTTP) ||
            (sp == iphc_pkg::PORT_HTTPS)) ? sp : dp;
    if (pick == iphc_pkg::PORT_NTP) begin
      result.service = iphc_pkg::SVC_NTP;
    end else if (pick == iphc_pkg::PORT_HTTP) begin
      result.service = iphc_pkg::SVC_HTTP;
    end else if (pick == iphc_pkg::PORT_HTTPS) begin
      result.service = udp_fit && !tcp_fit ? iphc_pkg::SVC_QUIC : iphc_pkg::SVC_TLS;
    end
    if ((pick == iphc_pkg::PORT_HTTP) && tcp_fit && acc_ok && http_fit && prefix_ok_nxt) begin
      result.http_status = accum_nxt;
    end
  end

  // A result clears the whole parse state for the next packet.
  always_ff @(posedge clk) begin
    if (!rst_n || (take && item.last_byte)) begin
      pos_r       <= '0;
      kind_r      <= '0;
      toff_r      <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      tcp_hdr_r   <= '0;
      prefix_ok_r <= 1'b0;
      phase_r     <= iphc_pkg::SCAN_LEAD;
      accum_r     <= '0;
    end else if (take) begin
      pos_r       <= pos_nxt;
      kind_r      <= kind_nxt;
      toff_r      <= toff_nxt;
      proto_r     <= proto_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      tcp_hdr_r   <= tcp_hdr_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      phase_r     <= phase_nxt;
      accum_r     <= accum_nxt;
    end
  end

endmodule

// ===== sv/iphc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module iphc_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  iphc_pkg::result_t  result,
  output logic               free,
  iphc_out_if.source         out_ch
);

  logic              valid_r;
  logic              valid_nxt;
  iphc_pkg::result_t result_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.accepted      = result_r.accepted;
  assign out_ch.ip_version    = result_r.ip_version;
  assign out_ch.transport     = result_r.transport;
  assign out_ch.service       = result_r.service;
  assign out_ch.source_port   = result_r.source_port;
  assign out_ch.dest_port     = result_r.dest_port;
  assign out_ch.packet_length = result_r.packet_length;
  assign out_ch.http_status   = result_r.http_status;

endmodule

// ===== sv/ip_packet_header_classifier_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - top level
// Parses IPv4/IPv6 packets byte by byte and reports a classification result.
// ----------------------------------------------------------------------------
// The classifier takes one packet byte per input transaction, starting at the
// IP header, with the link protocol number sampled on the first byte, and
// produces exactly one result transaction for each byte that carries the last
// byte flag. It sustains one byte per clock cycle unless a last byte stalls:
// a byte is registered at the input and then folded into the parse state, and
// on the last byte the result is written to the output register as that byte
// is folded in, provided the output register is free at that point. The
// output register decouples the two sides; input bytes keep flowing while a
// result waits, and only a last byte stalls (for as long as the previous
// result has not been taken). The result reports acceptance (IPv4 of at least
// 20 bytes, IPv6 of at least 40), IP version, TCP/UDP/other transport, both
// ports, a service picked from the ports, the byte count (saturating at
// 65535) and an HTTP status code read from a TCP payload that starts with
// "HTTP/". No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module ip_packet_header_classifier_top (
  input  logic       clk,
  input  logic       rst_n,
  iphc_in_if.sink    in_ch,
  iphc_out_if.source out_ch
);

  iphc_pkg::stage_t  stage;
  iphc_pkg::result_t result;
  logic              out_free;
  logic              take;

  // A byte moves into the parser unless it ends a packet and the result
  // register is still occupied.
  assign take = stage.valid && (!stage.item.last_byte || out_free);

  iphc_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  iphc_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (stage.item),
    .result (result)
  );

  iphc_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take && stage.item.last_byte),
    .result (result),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

// ===== sv/iphc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IP packet header classifier - port checker
// Checks result consistency and output hold behavior on the top-level ports.
// ----------------------------------------------------------------------------
`include "ip_packet_header_classifier_top_defines.svh"

module iphc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic        ip_version,
  input logic [1:0]  transport,
  input logic [2:0]  service,
  input logic [15:0] source_port,
  input logic [15:0] dest_port,
  input logic [15:0] packet_length,
  input logic [15:0] http_status
);

  // A stalled result stays valid and keeps its length, status and source port.
  `IPHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(packet_length) && $stable(http_status) && $stable(source_port))

  // A dropped packet reports only its length.
  `IPHC_ASSERT_IMPL(a_drop_clean, out_valid && !accepted, !ip_version && transport == iphc_pkg::TRN_OTHER && service == iphc_pkg::SVC_UNKNOWN && source_port == 16'd0 && dest_port == 16'd0 && http_status == 16'd0)

  // Ports are reported only for TCP and UDP.
  `IPHC_ASSERT_IMPL(a_ports_need_l4, out_valid && transport == iphc_pkg::TRN_OTHER, source_port == 16'd0 && dest_port == 16'd0)

  // A status code comes only from HTTP over TCP.
  `IPHC_ASSERT_IMPL(a_status_http, out_valid && http_status != 16'd0, accepted && transport == iphc_pkg::TRN_TCP && service == iphc_pkg::SVC_HTTP)

endmodule

bind ip_packet_header_classifier_top iphc_checker u_iphc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .accepted      (out_ch.accepted),
  .ip_version    (out_ch.ip_version),
  .transport     (out_ch.transport),
  .service       (out_ch.service),
  .source_port   (out_ch.source_port),
  .dest_port     (out_ch.dest_port),
  .packet_length (out_ch.packet_length),
  .http_status   (out_ch.http_status)
);
